/* src/abcrs_pkg.sv */
// Package for the dual-bank configuration record selector: types, constants, CRC function.
`default_nettype none
package abcrs_pkg;
  localparam int SETTING_COUNT = 4;
  localparam logic [31:0] RECORD_MAGIC = 32'h43464731;
  localparam logic [15:0] RECORD_VERSION = 16'd1;
  localparam logic [15:0] SETPOINT_LOW_RST = 16'd200;
  localparam logic [15:0] SETPOINT_HIGH_RST = 16'd800;
  localparam logic [4:0] CRC_SPAN = 5'd20;
  localparam logic [4:0] MIN_BYTES = 5'd22;
  localparam logic [4:0] MAX_BYTES = 5'd24;
  localparam logic [1:0] REG_STORAGE_READY = 2'd0;
  localparam logic [1:0] REG_SETPOINT_LOW = 2'd1;
  localparam logic [1:0] REG_SETPOINT_HIGH = 2'd2;

  // one finished record handed from the parser to the selector
  typedef struct packed {
    logic        from_slot_b;
    logic        record_ok;
    logic [31:0] sequence_num;
    logic [15:0] set0;
    logic [15:0] set1;
    logic [15:0] set2;
    logic [15:0] set3;
    logic        clear_choice;
    logic        record_end;
  } rec_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction
endpackage
`default_nettype wire

/* src/abcrs_parser.sv */
// Front part: parses record bytes, runs the CRC and classifies each record at its end.
`default_nettype none
module abcrs_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              from_slot_b,
  input  wire logic              record_end,
  input  wire logic [15:0]       setpoint_low,
  input  wire logic [15:0]       setpoint_high,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output abcrs_pkg::rec_t        q_data
);
  import abcrs_pkg::*;

  logic [4:0]  byte_count;
  logic [15:0] crc_acc;
  logic [31:0] magic_word;
  logic [15:0] version_word;
  logic [31:0] rec_seq;
  logic [15:0] rec_set [SETTING_COUNT];
  logic [15:0] stored_check;
  logic        fire;
  logic [4:0]  pos;
  logic [15:0] crc_next;
  logic [31:0] magic_next;
  logic [15:0] version_next;
  logic [31:0] seq_next;
  logic [15:0] set_next [SETTING_COUNT];
  logic [15:0] check_next;
  logic [4:0]  count_next;
  logic [4:0]  rel;
  logic        ok;

  assign in_ready = q_ready;
  assign fire = in_valid && in_ready;
  assign pos = byte_count;
  assign rel = pos - 5'd12;

  always_comb begin
    crc_next = crc_acc;
    magic_next = magic_word;
    version_next = version_word;
    seq_next = rec_seq;
    for (int i = 0; i < SETTING_COUNT; i++) set_next[i] = rec_set[i];
    check_next = stored_check;
    count_next = byte_count;
    if (pos < MAX_BYTES) begin
      count_next = pos + 5'd1;
      if (pos < CRC_SPAN) crc_next = crc_byte(crc_acc, data_byte);
      if (pos < 5'd4) magic_next[pos[1:0]*8 +: 8] = data_byte;
      else if (pos < 5'd6) version_next[pos[0]*8 +: 8] = data_byte;
      else if (pos < 5'd8) begin
      end else if (pos < 5'd12) seq_next[pos[1:0]*8 +: 8] = data_byte;
      else if (pos < 5'd20) set_next[rel[2:1]][rel[0]*8 +: 8] = data_byte;
      else if (pos < 5'd22) check_next[pos[0]*8 +: 8] = data_byte;
    end
    ok = (count_next >= MIN_BYTES) && (magic_next == RECORD_MAGIC)
      && (version_next == RECORD_VERSION) && (check_next == crc_next)
      && (set_next[0] != 16'd0)
      && (set_next[1] >= setpoint_low) && (set_next[1] <= setpoint_high)
      && (set_next[2] >= setpoint_low) && (set_next[2] <= setpoint_high)
      && (set_next[3] <= 16'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      crc_acc <= 16'hFFFF;
      magic_word <= '0;
      version_word <= '0;
      rec_seq <= '0;
      for (int i = 0; i < SETTING_COUNT; i++) rec_set[i] <= '0;
      stored_check <= '0;
      q_valid <= 1'b0;
    end else begin
      if (fire) q_valid <= 1'b1;
      else if (q_ready) q_valid <= 1'b0;
      if (fire) begin
        q_data.from_slot_b <= from_slot_b;
        q_data.record_ok <= ok;
        q_data.sequence_num <= seq_next;
        q_data.set0 <= set_next[0];
        q_data.set1 <= set_next[1];
        q_data.set2 <= set_next[2];
        q_data.set3 <= set_next[3];
        q_data.clear_choice <= (byte_count == 5'd0) && !from_slot_b;
        q_data.record_end <= record_end;
        if (record_end) begin
          byte_count <= '0;
          crc_acc <= 16'hFFFF;
          magic_word <= '0;
          version_word <= '0;
          rec_seq <= '0;
          for (int i = 0; i < SETTING_COUNT; i++) rec_set[i] <= '0;
          stored_check <= '0;
        end else begin
          byte_count <= count_next;
          crc_acc <= crc_next;
          magic_word <= magic_next;
          version_word <= version_next;
          rec_seq <= seq_next;
          for (int i = 0; i < SETTING_COUNT; i++) rec_set[i] <= set_next[i];
          stored_check <= check_next;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* src/abcrs_selector.sv */
// Back part: keeps the running choice and drives the result register.
`default_nettype none
module abcrs_selector (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire abcrs_pkg::rec_t q_data,
  input  wire logic        storage_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_valid,
  output logic             have_choice,
  output logic             chosen_slot,
  output logic [31:0]      chosen_sequence,
  output logic [15:0]      setting_0,
  output logic [15:0]      setting_1,
  output logic [15:0]      setting_2,
  output logic             setting_3
);
  import abcrs_pkg::*;

  logic        choice_valid;
  logic        choice_slot;
  logic [31:0] choice_seq;
  logic [15:0] choice_set0, choice_set1, choice_set2, choice_set3;
  logic        cv, cs;
  logic [31:0] cq;
  logic [15:0] c0, c1, c2, c3;
  logic        valid, take, show, fire;

  assign q_ready = !out_valid || out_ready;
  assign fire = q_valid && q_ready;

  always_comb begin
    cv = choice_valid; cs = choice_slot; cq = choice_seq;
    c0 = choice_set0; c1 = choice_set1; c2 = choice_set2; c3 = choice_set3;
    if (q_data.clear_choice) begin
      cv = 1'b0; cs = 1'b0; cq = '0; c0 = '0; c1 = '0; c2 = '0; c3 = '0;
    end
    valid = storage_ready && q_data.record_ok;
    take = valid && (!q_data.from_slot_b || !cv || (q_data.sequence_num > cq));
    if (q_data.record_end && take) begin
      cv = 1'b1; cs = q_data.from_slot_b; cq = q_data.sequence_num;
      c0 = q_data.set0; c1 = q_data.set1; c2 = q_data.set2; c3 = q_data.set3;
    end
    show = storage_ready && cv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      choice_valid <= 1'b0;
      choice_slot <= 1'b0;
      choice_seq <= '0;
      choice_set0 <= '0; choice_set1 <= '0; choice_set2 <= '0; choice_set3 <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire && q_data.record_end) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (fire) begin
        choice_valid <= cv; choice_slot <= cs; choice_seq <= cq;
        choice_set0 <= c0; choice_set1 <= c1; choice_set2 <= c2; choice_set3 <= c3;
        if (q_data.record_end) begin
          record_valid <= valid;
          have_choice <= show;
          chosen_slot <= show & cs;
          chosen_sequence <= show ? cq : '0;
          setting_0 <= show ? c0 : '0;
          setting_1 <= show ? c1 : '0;
          setting_2 <= show ? c2 : '0;
          setting_3 <= show & c3[0];
        end
      end
    end
  end
endmodule
`default_nettype wire

/* src/ab_config_record_selector_top.sv */
// Top level of the dual-bank configuration record selector.
// Input channel (in_valid/in_ready) takes one record byte per request: data_byte,
// from_slot_b and record_end. Slot A's record comes first, then slot B's.
// A record ending with record_end produces one result request on the output
// channel (out_valid/out_ready); other bytes produce none.
// An accepted ending byte passes the parse register, then the result
// register. Throughput: one byte per cycle while in_ready is high; in_ready
// drops when the output stalls.
// Configuration: cfg_we/cfg_index/cfg_data write storage_ready (0),
// setpoint_low (1) and setpoint_high (2); write only while idle.
// Reset clears the parse state and choice; storage_ready resets to 0,
// limits to 200 and 800. When the receiver stalls the result is held and the
// parser stage holds one request; in_ready drops until the stall clears.
`default_nettype none
module ab_config_record_selector_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        from_slot_b,
  input  wire logic        record_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             record_valid,
  output logic             have_choice,
  output logic             chosen_slot,
  output logic [31:0]      chosen_sequence,
  output logic [15:0]      setting_0,
  output logic [15:0]      setting_1,
  output logic [15:0]      setting_2,
  output logic             setting_3,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import abcrs_pkg::*;

  logic        storage_ready;
  logic [15:0] setpoint_low, setpoint_high;
  logic        q_valid, q_ready;
  rec_t        q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      storage_ready <= 1'b0;
      setpoint_low <= SETPOINT_LOW_RST;
      setpoint_high <= SETPOINT_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STORAGE_READY: storage_ready <= cfg_data[0];
        REG_SETPOINT_LOW:  setpoint_low <= cfg_data;
        REG_SETPOINT_HIGH: setpoint_high <= cfg_data;
        default: ;
      endcase
    end
  end

  abcrs_parser u_parser (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .from_slot_b, .record_end,
    .setpoint_low, .setpoint_high, .q_valid, .q_ready, .q_data
  );

  abcrs_selector u_selector (
    .clk, .rst, .q_valid, .q_ready, .q_data, .storage_ready, .out_valid, .out_ready,
    .record_valid, .have_choice, .chosen_slot, .chosen_sequence,
    .setting_0, .setting_1, .setting_2, .setting_3
  );
endmodule
`default_nettype wire
